// File: rtl/core/anbs_pkg.sv
// ----------------------------------------------------------------------------
// anbs_pkg
// Shared types and constants for the Annex B start code parser: result
// layout, push bundle between parser and result queue, and sizes.
// ----------------------------------------------------------------------------
package anbs_pkg;

  localparam int LENGTH_BITS = 20;
  localparam int UNIT_LEN_W  = 20;
  localparam int MAX_PUSH    = 4;
  localparam int PUSH_N_W    = $clog2(MAX_PUSH + 1);
  localparam int HELD_DEPTH  = 3;
  localparam int QDEPTH      = 8;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [7:0] FORBIDDEN_MASK = 8'h80;
  localparam logic [7:0] REF_IDC_MASK   = 8'h60;
  localparam logic [7:0] TYPE_MASK      = 8'h1f;

  localparam logic [2:0] PREFIX_SHORT = 3'd3;
  localparam logic [2:0] PREFIX_LONG  = 3'd4;

  typedef struct packed {
    logic [7:0]            payload_byte;
    logic                  unit_first;
    logic                  unit_last;
    logic                  forbidden_flag;
    logic [1:0]            ref_idc;
    logic [4:0]            unit_type;
    logic [2:0]            prefix_length;
    logic [UNIT_LEN_W-1:0] unit_length;
    logic                  sync_error;
  } result_t;

  typedef struct packed {
    logic [PUSH_N_W-1:0]         n;
    result_t [MAX_PUSH-1:0]      entry;
  } push_t;

endpackage

// File: rtl/core/annexb_nal_unit_splitter_unit.sv
// ----------------------------------------------------------------------------
// annexb_nal_unit_splitter_unit
// Annex B start code parser: strips 3- and 4-byte start codes and streams
// NAL unit bytes with first/last marks and header fields.
// ----------------------------------------------------------------------------
// Takes one stream byte per clock while the result queue has room. Each
// byte is parsed in the cycle it is accepted; its results (up to four when
// a buffer end flushes the hold window) go to an eight-entry queue that
// drains one per clock while the output is ready; a result shows on the
// output at the earliest in the cycle after its byte. Input is ready while
// at most four results wait; with the output taking one result per clock
// the block sustains one byte per clock. Unit bytes are held back by up to
// three bytes until it is known whether they belong to a start code.
module annexb_nal_unit_splitter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tlast,   // end_of_buffer
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // payload_byte, forbidden_flag, ref_idc, unit_type,
                                 // prefix_length, unit_length, zero pad
  output logic [1:0]  m_tuser,   // unit_first, sync_error
  output logic        m_tlast    // unit_last
);

  anbs_pkg::push_t   push;
  anbs_pkg::result_t head;
  logic              room;
  logic              take;

  assign s_tready = room;
  assign take     = s_tvalid && room;

  anbs_parse u_parse (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .data_byte     (s_tdata),
    .end_of_buffer (s_tlast),
    .push          (push)
  );

  anbs_rqueue u_rqueue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .head      (head)
  );

  assign m_tdata = {1'b0, head.unit_length, head.prefix_length, head.unit_type,
                    head.ref_idc, head.forbidden_flag, head.payload_byte};
  assign m_tuser = {head.sync_error, head.unit_first};
  assign m_tlast = head.unit_last;

endmodule

// File: rtl/core/anbs_parse.sv
// ----------------------------------------------------------------------------
// anbs_parse
// Start code detection and unit tracking. Each accepted byte updates the
// hold window and unit state and yields up to four results in one cycle.
// ----------------------------------------------------------------------------
module anbs_parse (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          data_byte,
  input  logic                end_of_buffer,
  output anbs_pkg::push_t     push
);

  localparam int L = anbs_pkg::LENGTH_BITS;

  logic [7:0]   held [anbs_pkg::HELD_DEPTH];
  logic [1:0]   held_count;
  logic         inside_unit;
  logic         header_seen;
  logic [7:0]   header_fields;
  logic         prefix_four;
  logic [L-1:0] byte_counter;

  logic [7:0]   held_next [anbs_pkg::HELD_DEPTH];
  logic [1:0]   held_count_next;
  logic         inside_unit_next;
  logic         header_seen_next;
  logic [7:0]   header_fields_next;
  logic         prefix_four_next;
  logic [L-1:0] byte_counter_next;

  logic [7:0]   s [4];
  logic [2:0]   len;
  logic [2:0]   t;
  logic         run;
  logic [2:0]   keep;
  logic [2:0]   rel;
  logic [2:0]   idx;
  logic         zero_pair;
  logic         term;
  logic         close_unit;
  logic [2:0]   n;
  logic [L:0]   sum;
  logic [L-1:0] sat_count;
  logic [7:0]   hdr;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < {1'b0, held_count}) begin
        s[i] = held[i < anbs_pkg::HELD_DEPTH ? i : 0];
      end else if (3'(i) == {1'b0, held_count}) begin
        s[i] = data_byte;
      end else begin
        s[i] = 8'h00;
      end
    end
    len = {1'b0, held_count} + 3'd1;

    // trailing zeros of the window plus the new byte
    t   = 3'd0;
    run = 1'b1;
    for (int i = 3; i >= 0; i--) begin
      if (3'(i) < len) begin
        if (run && s[i] == 8'h00) begin
          t = t + 3'd1;
        end else begin
          run = 1'b0;
        end
      end
    end
    keep = (t < len) ? t + 3'd1 : t;
    rel  = len - keep;

    zero_pair = (held_count == 2'd2 && held[0] == 8'h00 && held[1] == 8'h00) ||
                (held_count == 2'd3 && held[1] == 8'h00 && held[2] == 8'h00);
    term       = zero_pair && (data_byte[7:1] == 7'd0);
    close_unit = term || end_of_buffer;

    if (!inside_unit) begin
      n = (data_byte == 8'h00 || (data_byte == 8'h01 && held_count >= 2'd2)) ? 3'd0 : 3'd1;
    end else if (term) begin
      n = len - 3'd3;
    end else if (end_of_buffer) begin
      n = len;
    end else begin
      n = rel;
    end

    sum       = {1'b0, byte_counter} + (L+1)'(n);
    sat_count = sum[L] ? {L{1'b1}} : sum[L-1:0];
    hdr       = header_seen ? header_fields : s[0];
  end

  always_comb begin
    push.n = take ? n : '0;
    for (int i = 0; i < anbs_pkg::MAX_PUSH; i++) begin
      push.entry[i] = '0;
      if (inside_unit) begin
        push.entry[i].payload_byte   = s[i];
        push.entry[i].unit_first     = (i == 0) && !header_seen;
        push.entry[i].unit_last      = close_unit && (3'(i) == n - 3'd1);
        push.entry[i].forbidden_flag = |(hdr & anbs_pkg::FORBIDDEN_MASK);
        push.entry[i].ref_idc        = 2'((hdr & anbs_pkg::REF_IDC_MASK) >> 5);
        push.entry[i].unit_type      = 5'(hdr & anbs_pkg::TYPE_MASK);
        push.entry[i].prefix_length  = prefix_four ? anbs_pkg::PREFIX_LONG
                                                   : anbs_pkg::PREFIX_SHORT;
        push.entry[i].unit_length    = push.entry[i].unit_last
                                       ? anbs_pkg::UNIT_LEN_W'(sat_count) : '0;
      end else if (i == 0) begin
        push.entry[i].payload_byte = data_byte;
        push.entry[i].sync_error   = 1'b1;
      end
    end
  end

  always_comb begin
    held_next          = held;
    held_count_next    = held_count;
    inside_unit_next   = inside_unit;
    header_seen_next   = header_seen;
    header_fields_next = header_fields;
    prefix_four_next   = prefix_four;
    byte_counter_next  = byte_counter;
    idx                = 3'd0;

    if (inside_unit) begin
      if (n != 3'd0) begin
        header_seen_next   = 1'b1;
        header_fields_next = hdr;
        byte_counter_next  = sat_count;
      end
      if (term) begin
        if (data_byte[0]) begin
          header_seen_next   = 1'b0;
          header_fields_next = 8'h00;
          prefix_four_next   = 1'b0;
          byte_counter_next  = '0;
          held_count_next    = 2'd0;
        end else begin
          inside_unit_next = 1'b0;
          held_count_next  = 2'd3;
        end
      end else if (!end_of_buffer) begin
        for (int j = 0; j < anbs_pkg::HELD_DEPTH; j++) begin
          idx = rel + 3'(j);
          held_next[j] = idx[2] ? 8'h00 : s[idx[1:0]];
        end
        held_count_next = keep[1:0];
      end
    end else begin
      if (data_byte == 8'h00) begin
        held_count_next = (held_count == 2'd3) ? 2'd3 : held_count + 2'd1;
      end else if (data_byte == 8'h01 && held_count >= 2'd2) begin
        inside_unit_next   = 1'b1;
        header_seen_next   = 1'b0;
        header_fields_next = 8'h00;
        prefix_four_next   = (held_count == 2'd3);
        byte_counter_next  = '0;
        held_count_next    = 2'd0;
      end else begin
        held_count_next = 2'd0;
      end
    end

    if (end_of_buffer) begin
      inside_unit_next = 1'b0;
      header_seen_next = 1'b0;
      held_count_next  = 2'd0;
      for (int j = 0; j < anbs_pkg::HELD_DEPTH; j++) begin
        held_next[j] = 8'h00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count    <= 2'd0;
      inside_unit   <= 1'b0;
      header_seen   <= 1'b0;
      header_fields <= 8'h00;
      prefix_four   <= 1'b0;
      byte_counter  <= '0;
    end else if (take) begin
      held_count    <= held_count_next;
      inside_unit   <= inside_unit_next;
      header_seen   <= header_seen_next;
      header_fields <= header_fields_next;
      prefix_four   <= prefix_four_next;
      byte_counter  <= byte_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held <= held_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (take && end_of_buffer) |=> (!inside_unit && held_count == 2'd0))
    else $error("window not flushed at end of buffer");

  assert property (@(posedge clk) disable iff (rst)
    (push.n > 3'd1) |-> inside_unit)
    else $error("multiple results outside a unit");

endmodule

// File: rtl/core/anbs_rqueue.sv
// ----------------------------------------------------------------------------
// anbs_rqueue
// Result queue: takes up to four results per cycle and hands them out
// one per cycle on the output stream while the output is ready.
// ----------------------------------------------------------------------------
module anbs_rqueue (
  input  logic                clk,
  input  logic                rst,
  input  anbs_pkg::push_t     push,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output anbs_pkg::result_t   head
);

  localparam int PW = anbs_pkg::QPTR_W;
  localparam int CW = anbs_pkg::QCNT_W;

  anbs_pkg::result_t slots [anbs_pkg::QDEPTH];
  logic [PW-1:0]     rd_ptr;
  logic [PW-1:0]     wr_ptr;
  logic [CW-1:0]     count;
  logic              pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign head      = slots[rd_ptr];
  assign room      = (count <= CW'(anbs_pkg::QDEPTH - anbs_pkg::MAX_PUSH));

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push.n);
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + CW'(push.n) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < anbs_pkg::MAX_PUSH; k++) begin
      if (anbs_pkg::PUSH_N_W'(k) < push.n) begin
        slots[wr_ptr + PW'(k)] <= push.entry[k];
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (push.n != '0) |-> (count <= CW'(anbs_pkg::QDEPTH - anbs_pkg::MAX_PUSH)))
    else $error("push into full result queue");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(rd_ptr))
    else $error("read pointer moved on stall");

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Annex B start code parser. A short table of
// directed bytes (sync drops, both prefix lengths, zero runs, buffer ends on
// a start code) is followed by random buffers of well-formed units with some
// noise. Every result is checked field by field against a behavioral
// predictor or the table's expectation, with random idle bursts on both
// sides and one long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TARGET_ITEMS = 320;
  localparam int CALM_ITEMS   = 280;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 80;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 12;

  typedef enum logic [1:0] {BY_MODEL, NO_RESULT, SYNC_DROP} row_check_t;

  typedef struct {
    logic [7:0] data;
    logic       eob;
    row_check_t check;
  } dir_row_t;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  annexb_nal_unit_splitter_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // parser state mirror
  logic [7:0]                       win [4];
  int unsigned                      win_n     = 0;
  bit                               in_unit   = 1'b0;
  bit                               hdr_seen  = 1'b0;
  logic [7:0]                       hdr       = 8'h00;
  bit                               long_code = 1'b0;
  logic [anbs_pkg::LENGTH_BITS-1:0] unit_cnt  = '0;

  anbs_pkg::result_t expected_q [$];

  int errors       = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int units_closed = 0;
  int long_units   = 0;
  int drops_seen   = 0;
  int stall_cycles = 0;
  bit calm         = 1'b0;
  bit held_once    = 1'b0;

  dir_row_t dir_rows [26] = '{
    '{8'hFF, 1'b0, SYNC_DROP},
    '{8'h01, 1'b0, SYNC_DROP},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h01, 1'b0, SYNC_DROP},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h01, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, BY_MODEL},
    '{8'h00, 1'b0, BY_MODEL},
    '{8'h00, 1'b0, BY_MODEL},
    '{8'h03, 1'b0, BY_MODEL},
    '{8'h00, 1'b0, BY_MODEL},
    '{8'h00, 1'b0, BY_MODEL},
    '{8'h00, 1'b0, BY_MODEL},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h01, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, BY_MODEL},
    '{8'h80, 1'b1, BY_MODEL},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h01, 1'b0, NO_RESULT},
    '{8'h7F, 1'b0, BY_MODEL},
    '{8'h00, 1'b0, BY_MODEL},
    '{8'h00, 1'b0, BY_MODEL},
    '{8'h01, 1'b1, BY_MODEL}
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    for (int k = 0; k < 4; k++) win[k] = 8'h00;
  end

  function automatic void emit_unit_byte(logic [7:0] b, bit last);
    anbs_pkg::result_t r;
    bit first;
    first = !hdr_seen;
    if (first) begin
      hdr = b;
      hdr_seen = 1'b1;
    end
    if (unit_cnt != {anbs_pkg::LENGTH_BITS{1'b1}}) unit_cnt = unit_cnt + 1'b1;
    r = '0;
    r.payload_byte   = b;
    r.unit_first     = first;
    r.unit_last      = last;
    r.forbidden_flag = hdr[7];
    r.ref_idc        = hdr[6:5];
    r.unit_type      = hdr[4:0];
    r.prefix_length  = long_code ? anbs_pkg::PREFIX_LONG : anbs_pkg::PREFIX_SHORT;
    r.unit_length    = last ? unit_cnt[anbs_pkg::UNIT_LEN_W-1:0] : '0;
    expected_q.push_back(r);
  endfunction

  function automatic void open_unit(bit four);
    in_unit   = 1'b1;
    hdr_seen  = 1'b0;
    hdr       = 8'h00;
    long_code = four;
    unit_cnt  = '0;
    win_n     = 0;
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic eob);
    logic [7:0] s [4];
    int len;
    int t;
    int keep;
    int rel;
    int i;
    anbs_pkg::result_t r;
    if (in_unit) begin
      len = (win_n > 3) ? 3 : win_n;
      for (i = 0; i < len; i++) s[i] = win[i];
      s[len] = b;
      len++;
      if (len >= 3 && s[len-3] == 8'h00 && s[len-2] == 8'h00 && b <= 8'h01) begin
        for (i = 0; i + 3 < len; i++) emit_unit_byte(s[i], i + 4 == len);
        if (b == 8'h01) begin
          open_unit(1'b0);
        end else begin
          in_unit = 1'b0;
          win_n   = 3;
        end
      end else if (eob) begin
        for (i = 0; i < len; i++) emit_unit_byte(s[i], i + 1 == len);
      end else begin
        t = 0;
        while (t < len && s[len-1-t] == 8'h00) t++;
        keep = (t < len) ? t + 1 : t;
        rel  = len - keep;
        for (i = 0; i < rel; i++) emit_unit_byte(s[i], 1'b0);
        for (i = 0; i < 4; i++) win[i] = 8'h00;
        for (i = 0; i < keep; i++) win[i] = s[rel + i];
        win_n = keep;
      end
    end else begin
      if (b == 8'h00) begin
        if (win_n < 3) win_n++;
      end else if (b == 8'h01 && win_n >= 2) begin
        open_unit(win_n >= 3);
      end else begin
        r = '0;
        r.payload_byte = b;
        r.sync_error   = 1'b1;
        expected_q.push_back(r);
        win_n = 0;
      end
    end
    if (eob) begin
      in_unit  = 1'b0;
      hdr_seen = 1'b0;
      win_n    = 0;
      for (i = 0; i < 4; i++) win[i] = 8'h00;
    end
  endfunction

  task automatic send_request(logic [7:0] b, logic eob, row_check_t check);
    int n0;
    anbs_pkg::result_t r;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eob;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n0 = expected_q.size();
    parse_byte(b, eob);
    if (check != BY_MODEL) begin
      while (expected_q.size() > n0) void'(expected_q.pop_back());
      if (check == SYNC_DROP) begin
        r = '0;
        r.payload_byte = b;
        r.sync_error   = 1'b1;
        expected_q.push_back(r);
      end
    end
    items_sent++;
    calm = (items_sent >= CALM_ITEMS);
    if (!calm && ((items_sent / 40) % 3 != 2) && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'h00;
      3:       return 8'h01;
      4:       return 8'h03;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random_buffer();
    logic [7:0] chunk [$];
    logic       ends [$];
    int units;
    int n;
    int u;
    int i;
    if ($urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) begin
        chunk.push_back(pick_byte());
        ends.push_back($urandom_range(0, 3) == 0);
      end
    end else begin
      repeat ($urandom_range(0, 2)) chunk.push_back(8'h00);
      units = $urandom_range(1, 3);
      for (u = 0; u < units; u++) begin
        if ($urandom_range(0, 9) != 0) begin
          if ($urandom_range(0, 1)) chunk.push_back(8'h00);
          chunk.push_back(8'h00);
          chunk.push_back(8'h00);
          chunk.push_back(8'h01);
        end
        n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
        for (i = 0; i < n; i++)
          chunk.push_back(i == 0 ? 8'($urandom_range(0, 255)) : pick_byte());
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 3)) chunk.push_back(8'h00);
      end
      for (i = 0; i < chunk.size(); i++) ends.push_back(i == chunk.size() - 1);
    end
    for (i = 0; i < chunk.size(); i++) send_request(chunk[i], ends[i], BY_MODEL);
  endtask

  task automatic check_result(anbs_pkg::result_t got, anbs_pkg::result_t want);
    if (got.payload_byte !== want.payload_byte) begin
      $error("payload_byte: expected %0h, actual %0h", want.payload_byte, got.payload_byte);
      errors++;
    end
    if (got.unit_first !== want.unit_first) begin
      $error("unit_first: expected %0d, actual %0d", want.unit_first, got.unit_first);
      errors++;
    end
    if (got.unit_last !== want.unit_last) begin
      $error("unit_last: expected %0d, actual %0d", want.unit_last, got.unit_last);
      errors++;
    end
    if (got.forbidden_flag !== want.forbidden_flag) begin
      $error("forbidden_flag: expected %0d, actual %0d", want.forbidden_flag,
             got.forbidden_flag);
      errors++;
    end
    if (got.ref_idc !== want.ref_idc) begin
      $error("ref_idc: expected %0d, actual %0d", want.ref_idc, got.ref_idc);
      errors++;
    end
    if (got.unit_type !== want.unit_type) begin
      $error("unit_type: expected %0d, actual %0d", want.unit_type, got.unit_type);
      errors++;
    end
    if (got.prefix_length !== want.prefix_length) begin
      $error("prefix_length: expected %0d, actual %0d", want.prefix_length,
             got.prefix_length);
      errors++;
    end
    if (got.unit_length !== want.unit_length) begin
      $error("unit_length: expected %0d, actual %0d", want.unit_length, got.unit_length);
      errors++;
    end
    if (got.sync_error !== want.sync_error) begin
      $error("sync_error: expected %0d, actual %0d", want.sync_error, got.sync_error);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    anbs_pkg::result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = '0;
      got.payload_byte   = m_tdata[7:0];
      got.forbidden_flag = m_tdata[8];
      got.ref_idc        = m_tdata[10:9];
      got.unit_type      = m_tdata[15:11];
      got.prefix_length  = m_tdata[18:16];
      got.unit_length    = m_tdata[38:19];
      got.unit_first     = m_tuser[0];
      got.sync_error     = m_tuser[1];
      got.unit_last      = m_tlast;
      results_seen++;
      if (got.unit_last) units_closed++;
      if (got.unit_last && got.prefix_length == anbs_pkg::PREFIX_LONG) long_units++;
      if (got.sync_error) drops_seen++;
      if (expected_q.size() == 0) begin
        $error("unexpected result: payload_byte %0h", got.payload_byte);
        errors++;
      end else begin
        check_result(got, expected_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  // output side, with one long hold-off to back the block up
  initial begin
    @(negedge rst);
    forever begin
      if (!held_once && items_sent >= HOLD_AT) begin
        held_once = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && ((items_sent / 40) % 3 != 1) && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[k]) send_request(dir_rows[k].data, dir_rows[k].eob, dir_rows[k].check);
    while (items_sent < TARGET_ITEMS) send_random_buffer();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d stream bytes, %0d results checked", items_sent, results_seen);
    $display("%0d units closed (%0d with long prefix), %0d dropped bytes",
             units_closed, long_units, drops_seen);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/anbs_pkg.sv
rtl/core/anbs_parse.sv
rtl/core/anbs_rqueue.sv
rtl/core/annexb_nal_unit_splitter_unit.sv
bench/testbench.sv
